/* src/slfp_pkg.sv */
package slfp_pkg;

	// Default sizes
	localparam int HEADER_BYTES_DEF = 3;
	localparam int RING_DEPTH_DEF   = 32;

	// Register indexes on the configuration port
	localparam logic [2:0] REG_SYNC_FIRST  = 3'd0;
	localparam logic [2:0] REG_SYNC_SECOND = 3'd1;
	localparam logic [2:0] REG_CODE_GET    = 3'd2;
	localparam logic [2:0] REG_CODE_SET    = 3'd3;
	localparam logic [2:0] REG_CODE_SEND   = 3'd4;

	// Register reset values
	localparam logic [7:0] SYNC_FIRST_RST  = 8'd85;
	localparam logic [7:0] SYNC_SECOND_RST = 8'd170;
	localparam logic [7:0] CODE_GET_RST    = 8'd1;
	localparam logic [7:0] CODE_SET_RST    = 8'd2;
	localparam logic [7:0] CODE_SEND_RST   = 8'd3;

	// Command classes
	localparam logic [1:0] KIND_GET     = 2'd0;
	localparam logic [1:0] KIND_SET     = 2'd1;
	localparam logic [1:0] KIND_SEND    = 2'd2;
	localparam logic [1:0] KIND_UNKNOWN = 2'd3;

	typedef struct packed {
		logic [7:0] sync_first;
		logic [7:0] sync_second;
		logic [7:0] code_get_lines;
		logic [7:0] code_set_lines;
		logic [7:0] code_send_lines;
	} cfg_t;

	typedef struct packed {
		logic       frame_done;
		logic [1:0] command_kind;
		logic       fetch_pulse;
		logic       ring_write;
		logic [4:0] ring_index;
		logic [7:0] ring_data;
	} res_t;

endpackage

/* src/sync_length_frame_parser.sv */
// A byte accepted passes the input register, then the output register, before its result is on m_*.
// Throughput: one byte per cycle while m_tready keeps the output register draining.
// An input register and an output register let a byte enter while a result waits.
// Reset (arst_n low, asynchronous): parser idle, ring head 0, registers at defaults.
module sync_length_frame_parser
	import slfp_pkg::*;
#(
	parameter int HEADER_BYTES = HEADER_BYTES_DEF,
	parameter int RING_DEPTH   = RING_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// slave stream: [7:0] rx_byte
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,
	// master stream: [1:0] command_kind, [2] fetch_pulse, [3] ring_write,
	// [8:4] ring_index, [16:9] ring_data, [23:17] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t       cfg;
	res_t       res;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;

	// Process the held byte when the result register is free or emptying
	assign advance  = valid_s1 & (~m_tvalid | m_tready);
	assign s_tready = ~valid_s1 | advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			byte_s1 <= s_tdata;
	end

	slfp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	slfp_parse #(
		.HEADER_BYTES (HEADER_BYTES),
		.RING_DEPTH   (RING_DEPTH)
	) u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.byte_s1 (byte_s1),
		.cfg     (cfg),
		.res     (res)
	);

	slfp_outreg u_outreg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.res      (res),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

/* src/slfp_cfg.sv */
module slfp_cfg
	import slfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	// Write a register on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_first      <= SYNC_FIRST_RST;
			cfg_q.sync_second     <= SYNC_SECOND_RST;
			cfg_q.code_get_lines  <= CODE_GET_RST;
			cfg_q.code_set_lines  <= CODE_SET_RST;
			cfg_q.code_send_lines <= CODE_SEND_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_SYNC_FIRST:  cfg_q.sync_first      <= pwdata[7:0];
				REG_SYNC_SECOND: cfg_q.sync_second     <= pwdata[7:0];
				REG_CODE_GET:    cfg_q.code_get_lines  <= pwdata[7:0];
				REG_CODE_SET:    cfg_q.code_set_lines  <= pwdata[7:0];
				REG_CODE_SEND:   cfg_q.code_send_lines <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Return the addressed register
	always_comb begin
		prdata = '0;
		case (reg_idx)
			REG_SYNC_FIRST:  prdata[7:0] = cfg_q.sync_first;
			REG_SYNC_SECOND: prdata[7:0] = cfg_q.sync_second;
			REG_CODE_GET:    prdata[7:0] = cfg_q.code_get_lines;
			REG_CODE_SET:    prdata[7:0] = cfg_q.code_set_lines;
			REG_CODE_SEND:   prdata[7:0] = cfg_q.code_send_lines;
			default:         prdata = '0;
		endcase
	end

endmodule

/* src/slfp_parse.sv */
module slfp_parse
	import slfp_pkg::*;
#(
	parameter int HEADER_BYTES = HEADER_BYTES_DEF,
	parameter int RING_DEPTH   = RING_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  logic [7:0] byte_s1,
	input  cfg_t       cfg,
	output res_t       res
);

	localparam int HC_W = $clog2(HEADER_BYTES);
	localparam int RH_W = $clog2(RING_DEPTH);
	localparam logic [HC_W-1:0] HDR_LAST  = HC_W'(HEADER_BYTES - 1);
	localparam logic [RH_W-1:0] RING_LAST = RH_W'(RING_DEPTH - 1);

	logic            in_payload_q, in_header_q, saw_sync_first_q;
	logic [HC_W-1:0] header_count_q;
	logic [7:0]      command_byte_q, length_high_q, first_payload_q;
	logic [15:0]     payload_length_q, payload_count_q;
	logic [RH_W-1:0] ring_head_q;

	logic            in_payload_d, in_header_d, saw_sync_first_d;
	logic [HC_W-1:0] header_count_d;
	logic [7:0]      command_byte_d, length_high_d, first_payload_d;
	logic [15:0]     payload_length_d, payload_count_d;
	logic [RH_W-1:0] ring_head_d;

	logic [16:0]     pay_next;
	logic            done;
	logic [RH_W+4:0] head_ext;

	assign pay_next = {1'b0, payload_count_q} + 17'd1;
	assign head_ext = {5'b0, ring_head_q};

	// Parse one byte: next state and the result it causes
	always_comb begin
		in_payload_d     = in_payload_q;
		in_header_d      = in_header_q;
		saw_sync_first_d = saw_sync_first_q;
		header_count_d   = header_count_q;
		command_byte_d   = command_byte_q;
		length_high_d    = length_high_q;
		payload_length_d = payload_length_q;
		payload_count_d  = payload_count_q;
		first_payload_d  = first_payload_q;
		ring_head_d      = ring_head_q;
		done             = 1'b0;
		res              = '0;

		if (byte_s1 == cfg.code_send_lines && !in_payload_q && !saw_sync_first_q) begin
			// bare send opener starts a one-byte frame
			command_byte_d = byte_s1;
			in_payload_d   = 1'b1;
			header_count_d = '0;
		end else if (in_payload_q) begin
			if (payload_count_q == 16'd0)
				first_payload_d = byte_s1;
			if (pay_next >= {1'b0, payload_length_q}) begin
				done            = 1'b1;
				payload_count_d = '0;
			end else begin
				payload_count_d = pay_next[15:0];
			end
		end else if (in_header_q) begin
			if (header_count_q == HC_W'(0))
				command_byte_d = byte_s1;
			else if (header_count_q == HC_W'(1))
				length_high_d = byte_s1;
			else if (header_count_q == HC_W'(2))
				payload_length_d = {length_high_q, byte_s1};
			if (header_count_q == HDR_LAST) begin
				in_header_d    = 1'b0;
				in_payload_d   = 1'b1;
				header_count_d = '0;
			end else begin
				header_count_d = header_count_q + HC_W'(1);
			end
		end else if (byte_s1 == cfg.sync_first) begin
			saw_sync_first_d = 1'b1;
		end else if (byte_s1 == cfg.sync_second && saw_sync_first_q) begin
			in_header_d    = 1'b1;
			header_count_d = '0;
		end

		// Classify the finished frame
		if (done) begin
			res.frame_done = 1'b1;
			if (command_byte_d == cfg.code_get_lines) begin
				res.command_kind = KIND_GET;
				res.fetch_pulse  = 1'b1;
			end else if (command_byte_d == cfg.code_set_lines) begin
				res.command_kind = KIND_SET;
			end else if (command_byte_d == cfg.code_send_lines) begin
				res.command_kind = KIND_SEND;
				res.ring_write   = 1'b1;
				res.ring_index   = head_ext[4:0];
				res.ring_data    = first_payload_d;
				ring_head_d      = (ring_head_q == RING_LAST) ? '0 : ring_head_q + RH_W'(1);
			end else begin
				res.command_kind = KIND_UNKNOWN;
			end
			saw_sync_first_d = 1'b0;
			in_payload_d     = 1'b0;
			payload_length_d = '0;
			payload_count_d  = '0;
		end
	end

	// Hold parser state; advance on each processed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q     <= 1'b0;
			in_header_q      <= 1'b0;
			saw_sync_first_q <= 1'b0;
			header_count_q   <= '0;
			command_byte_q   <= '0;
			length_high_q    <= '0;
			payload_length_q <= '0;
			payload_count_q  <= '0;
			first_payload_q  <= '0;
			ring_head_q      <= '0;
		end else if (advance) begin
			in_payload_q     <= in_payload_d;
			in_header_q      <= in_header_d;
			saw_sync_first_q <= saw_sync_first_d;
			header_count_q   <= header_count_d;
			command_byte_q   <= command_byte_d;
			length_high_q    <= length_high_d;
			payload_length_q <= payload_length_d;
			payload_count_q  <= payload_count_d;
			first_payload_q  <= first_payload_d;
			ring_head_q      <= ring_head_d;
		end
	end

endmodule

/* src/slfp_outreg.sv */
module slfp_outreg
	import slfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  res_t        res,
	input  logic        m_tready,
	output logic        m_tvalid,
	output logic [23:0] m_tdata,
	output logic        m_tlast
);

	logic out_valid_q;
	res_t res_q;

	// Load a new result, or drop the one taken downstream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = res_q.frame_done;
	assign m_tdata  = {7'b0, res_q.ring_data, res_q.ring_index, res_q.ring_write,
		res_q.fetch_pulse, res_q.command_kind};

endmodule

/* tb/tb_sync_length_frame_parser.sv */
module tb_sync_length_frame_parser;
	import slfp_pkg::*;

	localparam int HDR_LEN     = HEADER_BYTES_DEF;
	localparam int RING_LEN    = RING_DEPTH_DEF;
	localparam int QUIET_LIMIT = 2000;

	// Header byte positions
	localparam logic [3:0] HDR_CMD     = 4'd0;
	localparam logic [3:0] HDR_LEN_MSB = 4'd1;
	localparam logic [3:0] HDR_LEN_LSB = 4'd2;

	// Register index with no register behind it
	localparam logic [2:0] REG_SPARE = 3'd7;

	localparam cfg_t CFG_RESET = '{SYNC_FIRST_RST, SYNC_SECOND_RST, CODE_GET_RST,
		CODE_SET_RST, CODE_SEND_RST};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready = 1'b1;
	logic [23:0] m_tdata;
	logic        m_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	sync_length_frame_parser DUT (
		.clk, .arst_n,
		.s_tvalid, .s_tready, .s_tdata,
		.m_tvalid, .m_tready, .m_tdata, .m_tlast,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	// Parser copy: configuration and frame state
	cfg_t        cfg;
	logic        payload_open;
	logic        header_open;
	logic        sync1_seen;
	logic [3:0]  hdr_pos;
	logic [7:0]  cmd_latched;
	logic [7:0]  len_msb;
	logic [15:0] pay_len;
	logic [15:0] pay_seen;
	logic [7:0]  lead_byte;
	int          ring_slot;

	res_t frame_reports_q[$];
	int   mismatches = 0;
	int   items_sent = 0;
	bit   idle_on = 1'b0;
	int   tready_hold_req = 0;
	int   hold_left = 0;
	int   stall_left = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Work out the report for one received byte and advance the parser copy
	function automatic res_t parse_rx_byte(input logic [7:0] b);
		res_t r;
		logic closed;
		r = '0;
		closed = 1'b0;
		if (b == cfg.code_send_lines && !payload_open && !sync1_seen) begin
			cmd_latched  = b;
			payload_open = 1'b1;
			hdr_pos      = '0;
		end else if (payload_open) begin
			if (pay_seen == 16'd0)
				lead_byte = b;
			if ({1'b0, pay_seen} + 17'd1 >= {1'b0, pay_len}) begin
				closed   = 1'b1;
				pay_seen = '0;
			end else begin
				pay_seen = pay_seen + 16'd1;
			end
		end else if (header_open) begin
			case (hdr_pos)
				HDR_CMD:     cmd_latched = b;
				HDR_LEN_MSB: len_msb = b;
				HDR_LEN_LSB: pay_len = {len_msb, b};
				default: ;
			endcase
			if (int'(hdr_pos) + 1 >= HDR_LEN) begin
				header_open  = 1'b0;
				payload_open = 1'b1;
				hdr_pos      = '0;
			end else begin
				hdr_pos = hdr_pos + 4'd1;
			end
		end else if (b == cfg.sync_first) begin
			sync1_seen = 1'b1;
		end else if (b == cfg.sync_second && sync1_seen) begin
			header_open = 1'b1;
			hdr_pos     = '0;
		end

		// Classify the command of a finished frame
		if (closed) begin
			r.frame_done = 1'b1;
			if (cmd_latched == cfg.code_get_lines) begin
				r.command_kind = KIND_GET;
				r.fetch_pulse  = 1'b1;
			end else if (cmd_latched == cfg.code_set_lines) begin
				r.command_kind = KIND_SET;
			end else if (cmd_latched == cfg.code_send_lines) begin
				r.command_kind = KIND_SEND;
				r.ring_write   = 1'b1;
				r.ring_index   = 5'(ring_slot);
				r.ring_data    = lead_byte;
				ring_slot      = (ring_slot + 1 >= RING_LEN) ? 0 : ring_slot + 1;
			end else begin
				r.command_kind = KIND_UNKNOWN;
			end
			sync1_seen   = 1'b0;
			payload_open = 1'b0;
			pay_len      = '0;
			pay_seen     = '0;
		end
		return r;
	endfunction

	// Pick a command byte that matches no configured code
	function automatic logic [7:0] unknown_command();
		logic [7:0] b;
		do
			b = 8'($urandom());
		while (b == cfg.code_get_lines || b == cfg.code_set_lines ||
			b == cfg.code_send_lines);
		return b;
	endfunction

	function automatic logic [7:0] random_command();
		case ($urandom_range(0, 4))
			0: return cfg.code_get_lines;
			1: return cfg.code_set_lines;
			2, 3: return cfg.code_send_lines;
			default: return unknown_command();
		endcase
	endfunction

	// Noise leans on the sync and opener values, but never the second sync,
	// so that it cannot open a header with an arbitrary length
	function automatic logic [7:0] noise_byte();
		logic [7:0] b;
		case ($urandom_range(0, 3))
			0: b = cfg.sync_first;
			1: b = cfg.code_send_lines;
			default: b = 8'($urandom());
		endcase
		if (b == cfg.sync_second)
			b = b ^ 8'h01;
		return b;
	endfunction

	// Check each report against the oldest pending one, then record new requests
	always @(posedge clk) begin : report_check
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (frame_reports_q.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected report: done=%0b tdata=%06h", m_tlast, m_tdata);
				mismatches++;
			end else begin
				want = frame_reports_q.pop_front();
				if (m_tlast !== want.frame_done || m_tdata[1:0] !== want.command_kind ||
					m_tdata[2] !== want.fetch_pulse || m_tdata[3] !== want.ring_write ||
					m_tdata[8:4] !== want.ring_index || m_tdata[16:9] !== want.ring_data ||
					m_tdata[23:17] !== 7'd0) begin
					if (mismatches < 10) begin
						$display("mismatch: expected done=%0b kind=%0d fetch=%0b wr=%0b idx=%0d data=%02h",
							want.frame_done, want.command_kind, want.fetch_pulse,
							want.ring_write, want.ring_index, want.ring_data);
						$display("          got done=%0b kind=%0d fetch=%0b wr=%0b idx=%0d data=%02h pad=%02h",
							m_tlast, m_tdata[1:0], m_tdata[2], m_tdata[3],
							m_tdata[8:4], m_tdata[16:9], m_tdata[23:17]);
					end
					mismatches++;
				end
			end
		end
		if (arst_n && s_tvalid && s_tready)
			frame_reports_q.push_back(parse_rx_byte(s_tdata));
	end

	// Drive the master-side ready: long hold on request, else random stall bursts
	always @(negedge clk) begin
		if (tready_hold_req > 0) begin
			hold_left = tready_hold_req;
			tready_hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(0, 7);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// End the run when nothing moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
				quiet = 0;
			else
				quiet++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	// Send one byte request, with a random gap before it when idling is on
	task automatic push_rx_byte(input logic [7:0] b);
		int gap;
		@(negedge clk);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 8);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do
			@(posedge clk);
		while (!s_tready);
		items_sent++;
	endtask

	task automatic send_sync_frame(input logic [7:0] cmd, input logic [15:0] len);
		int n;
		n = (len == 16'd0) ? 1 : int'(len);
		push_rx_byte(cfg.sync_first);
		push_rx_byte(cfg.sync_second);
		push_rx_byte(cmd);
		push_rx_byte(len[15:8]);
		push_rx_byte(len[7:0]);
		repeat (n) push_rx_byte(8'($urandom()));
	endtask

	task automatic send_short_frame(input logic [7:0] d);
		push_rx_byte(cfg.code_send_lines);
		push_rx_byte(d);
	endtask

	// Stop sending and hold until every pending report has come back
	task automatic wait_results_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (frame_reports_q.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] idx, input logic [7:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {24'($urandom()), val};
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		case (idx)
			REG_SYNC_FIRST:  cfg.sync_first = val;
			REG_SYNC_SECOND: cfg.sync_second = val;
			REG_CODE_GET:    cfg.code_get_lines = val;
			REG_CODE_SET:    cfg.code_set_lines = val;
			REG_CODE_SEND:   cfg.code_send_lines = val;
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic apply_config(input cfg_t c);
		apb_write(REG_SYNC_FIRST, c.sync_first);
		apb_write(REG_SYNC_SECOND, c.sync_second);
		apb_write(REG_CODE_GET, c.code_get_lines);
		apb_write(REG_CODE_SET, c.code_set_lines);
		apb_write(REG_CODE_SEND, c.code_send_lines);
	endtask

	// Mostly well-formed frames with random content, some broken syncs and noise
	task automatic run_random_traffic(input int n_items);
		int stop_at;
		int pick;
		logic [15:0] len;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				if ($urandom_range(0, 3) == 0)
					len = 16'($urandom_range(0, 1));
				else
					len = 16'($urandom_range(2, 6));
				send_sync_frame(random_command(), len);
			end else if (pick < 75) begin
				send_short_frame(8'($urandom()));
			end else if (pick < 85) begin
				// first sync followed by noise, no second sync
				push_rx_byte(cfg.sync_first);
				repeat ($urandom_range(1, 3)) push_rx_byte(noise_byte());
			end else begin
				push_rx_byte(noise_byte());
			end
		end
	endtask

	task automatic test_reset_defaults_frames();
		// lone second sync: ignored
		push_rx_byte(SYNC_SECOND_RST);
		// bare send code opens a one-byte frame
		send_short_frame(8'h00);
		// send code after first sync is no opener; get frame of length 1
		push_rx_byte(SYNC_FIRST_RST);
		push_rx_byte(CODE_SEND_RST);
		push_rx_byte(SYNC_SECOND_RST);
		push_rx_byte(CODE_GET_RST);
		push_rx_byte(8'h00);
		push_rx_byte(8'h01);
		push_rx_byte(8'hFF);
		// set frame of length 0 still takes one byte; first sync inside payload
		push_rx_byte(SYNC_FIRST_RST);
		push_rx_byte(SYNC_SECOND_RST);
		push_rx_byte(CODE_SET_RST);
		push_rx_byte(8'h00);
		push_rx_byte(8'h00);
		push_rx_byte(SYNC_FIRST_RST);
		// unknown command, opener byte inside payload
		push_rx_byte(SYNC_FIRST_RST);
		push_rx_byte(SYNC_SECOND_RST);
		push_rx_byte(8'hFF);
		push_rx_byte(8'h00);
		push_rx_byte(8'h02);
		push_rx_byte(8'hA5);
		push_rx_byte(CODE_SEND_RST);
	endtask

	// Push enough send frames to wrap the ring head
	task automatic test_ring_wrap();
		repeat (RING_LEN + 2) send_short_frame(8'($urandom()));
	endtask

	task automatic test_config_sweep();
		cfg_t sweep[6];
		logic [39:0] rnd;
		sweep[0] = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
		sweep[1] = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
		// first sync equals the opener, get shadows set and send
		sweep[2] = '{8'h03, 8'hFF, 8'h03, 8'h03, 8'h03};
		sweep[3] = '{8'hAA, 8'h55, 8'h80, 8'h7F, 8'hFE};
		rnd = {$urandom(), 8'($urandom())};
		sweep[4] = rnd;
		rnd = {$urandom(), 8'($urandom())};
		sweep[5] = rnd;
		for (int i = 0; i < 6; i++) begin
			wait_results_drained();
			apply_config(sweep[i]);
			apb_write(REG_SPARE, 8'($urandom()));
			send_sync_frame(cfg.code_get_lines, 16'd1);
			send_sync_frame(cfg.code_set_lines, 16'd0);
			send_sync_frame(cfg.code_send_lines, 16'd2);
			send_sync_frame(unknown_command(), 16'd1);
			send_short_frame(8'($urandom()));
			push_rx_byte(noise_byte());
		end
	endtask

	task automatic test_backpressure();
		wait_results_drained();
		apply_config(CFG_RESET);
		idle_on = 1'b0;
		// hold the receiver while the sender keeps offering
		@(posedge clk);
		tready_hold_req = 120;
		repeat (6) send_short_frame(8'($urandom()));
		repeat (4) send_sync_frame(random_command(), 16'($urandom_range(0, 3)));
		// pause the sender until every report is back
		wait_results_drained();
		repeat (3) send_sync_frame(random_command(), 16'($urandom_range(1, 4)));
		idle_on = 1'b1;
	endtask

	task automatic test_random_traffic();
		logic [39:0] rnd;
		for (int p = 0; p < 3; p++) begin
			wait_results_drained();
			rnd = {$urandom(), 8'($urandom())};
			apply_config(p == 0 ? CFG_RESET : cfg_t'(rnd));
			run_random_traffic(15);
			// one frame with a length above 255
			if (p == 1)
				send_sync_frame(random_command(), 16'h0100 + 16'($urandom_range(0, 8)));
		end
	endtask

	task automatic test_final_burst();
		idle_on = 1'b0;
		run_random_traffic(20);
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		cfg          = CFG_RESET;
		payload_open = 1'b0;
		header_open  = 1'b0;
		sync1_seen   = 1'b0;
		hdr_pos      = '0;
		cmd_latched  = '0;
		len_msb      = '0;
		pay_len      = '0;
		pay_seen     = '0;
		lead_byte    = '0;
		ring_slot    = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		idle_on = 1'b1;
		test_reset_defaults_frames();
		test_ring_wrap();
		test_config_sweep();
		test_backpressure();
		test_random_traffic();
		test_final_burst();

		wait_results_drained();
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* sync_length_frame_parser.f */
src/slfp_pkg.sv
src/slfp_cfg.sv
src/slfp_parse.sv
src/slfp_outreg.sv
src/sync_length_frame_parser.sv
tb/tb_sync_length_frame_parser.sv
